### hw/rtl/pcbs_pkg.sv
// Shared types and constants for the per-class box suppression block.
package pcbs_pkg;

	localparam int MAX_BOXES  = 64;
	localparam int IOU_STAGES = 4;
	localparam int RING_LEN   = MAX_BOXES + IOU_STAGES;
	localparam int ROT_W      = $clog2(RING_LEN);
	localparam int COUNT_W    = $clog2(MAX_BOXES + 1);
	localparam int THR_W      = 17;
	localparam logic [THR_W-1:0] THR_RESET = 17'd29491;

	typedef struct packed {
		logic [15:0] center_x;
		logic [15:0] center_y;
		logic [15:0] box_width;
		logic [15:0] box_height;
		logic [15:0] score;
		logic [7:0]  class_index;
		logic        last_in_set;
	} in_t;

	typedef struct packed {
		logic [15:0] kept_x;
		logic [15:0] kept_y;
		logic [15:0] kept_width;
		logic [15:0] kept_height;
		logic [15:0] kept_score;
		logic [7:0]  kept_class;
		logic        final_result;
		logic        overflowed;
	} out_t;

	// one stored detection as it travels along the chain
	typedef struct packed {
		logic        valid;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] w;
		logic [15:0] h;
		logic [15:0] score;
		logic [7:0]  cls;
	} entry_t;

	typedef enum logic [1:0] {
		ST_LOAD  = 2'b01,
		ST_SWEEP = 2'b10
	} state_t;

endpackage

### hw/rtl/per_class_box_suppression.sv
// Top level of the per-class greedy box suppression block.
//
//  channel   direction  handshake                 payload
//  in        in         in_valid / in_stall       in_data (pcbs_pkg::in_t)
//  out       out        out_valid / out_stall     out_data (pcbs_pkg::out_t)
//  cfg       in         cfg_wr_en                 cfg_wr_data (IoU threshold)
//
// Loading takes one detection per cycle; each lands in score order in the cell chain.
// After the transaction marked last, the chain rotates through the IoU pipeline in passes
// around the ring; each pass takes the first live entry as the next kept box and kills
// same-class overlaps. A set takes one pass per kept box and a final empty pass, stretched by
// output stalls; in_stall is high throughout. A stalled output freezes the chain.
// Reset clears the chain, counters and threshold (to 29491); no clearing pass is needed.
module per_class_box_suppression (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  pcbs_pkg::in_t               in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output pcbs_pkg::out_t              out_data,
	input  logic                        cfg_wr_en,
	input  logic [pcbs_pkg::THR_W-1:0]  cfg_wr_data
);
	import pcbs_pkg::*;

	state_t               state_q;
	logic [THR_W-1:0]     thr_q;
	logic [COUNT_W-1:0]   count_q;
	logic                 ovf_q;
	logic [ROT_W-1:0]     rot_q;
	logic                 found_q;
	logic                 have_pend_q;
	entry_t               pend_q;
	out_t                 out_q;
	logic                 out_valid_q;

	entry_t               cells [MAX_BOXES];
	logic [MAX_BOXES-1:0] keeps;
	entry_t               new_e, head_in, iou_out;
	logic                 accept, load_en, adv, out_free, take_ref, pass_end, emit;

	assign in_stall  = (state_q != ST_LOAD);
	assign accept    = in_valid && !in_stall;
	assign load_en   = accept && (count_q < COUNT_W'(MAX_BOXES));
	assign out_free  = !out_valid_q || !out_stall;
	assign adv       = (state_q == ST_SWEEP) && out_free;
	// first live entry of a pass is the next kept box
	assign take_ref  = adv && !found_q && cells[0].valid;
	assign pass_end  = adv && (rot_q == ROT_W'(RING_LEN - 1));
	// a new kept box pushes out the held one; an empty pass releases it as final
	assign emit      = adv && ((take_ref && have_pend_q) || (pass_end && !found_q && !take_ref));
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		new_e.valid = 1'b1;
		new_e.x     = in_data.center_x;
		new_e.y     = in_data.center_y;
		new_e.w     = in_data.box_width;
		new_e.h     = in_data.box_height;
		new_e.score = in_data.score;
		new_e.cls   = in_data.class_index;
		head_in     = cells[0];
		if (take_ref) begin
			head_in.valid = 1'b0;
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < MAX_BOXES; gi++) begin : g_cell
			entry_t prev_e, next_e;
			logic   prev_keeps;
			if (gi == 0) begin : g_head
				assign prev_e     = new_e;
				assign prev_keeps = 1'b1;
			end else begin : g_body
				assign prev_e     = cells[gi-1];
				assign prev_keeps = keeps[gi-1];
			end
			if (gi == MAX_BOXES - 1) begin : g_tail
				assign next_e = iou_out;
			end else begin : g_mid
				assign next_e = cells[gi+1];
			end
			pcbs_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.load_en    (load_en),
				.rot_en     (adv),
				.new_e      (new_e),
				.prev_e     (prev_e),
				.next_e     (next_e),
				.prev_keeps (prev_keeps),
				.cur        (cells[gi]),
				.keeps      (keeps[gi])
			);
		end
	endgenerate

	pcbs_iou u_iou (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.thr    (thr_q),
		.ref_e  (pend_q),
		.e_in   (head_in),
		.e_out  (iou_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			rot_q       <= '0;
			found_q     <= 1'b0;
			have_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (out_valid_q && !out_stall) begin
						out_valid_q <= 1'b0;
					end
					if (accept) begin
						if (in_data.last_in_set) begin
							state_q <= ST_SWEEP;
							count_q <= '0;
							rot_q   <= '0;
							found_q <= 1'b0;
						end else if (load_en) begin
							count_q <= count_q + COUNT_W'(1);
						end
						if (!load_en) begin
							ovf_q <= 1'b1;
						end
					end
				end
				ST_SWEEP: begin
					// no advance means the output register is held by a stall
					if (adv) begin
						out_valid_q <= emit;
						if (pass_end) begin
							rot_q   <= '0;
							found_q <= 1'b0;
						end else begin
							rot_q <= rot_q + ROT_W'(1);
							if (take_ref) begin
								found_q <= 1'b1;
							end
						end
						if (take_ref) begin
							have_pend_q <= 1'b1;
						end else if (pass_end && !found_q) begin
							// empty pass: the held box is the last one
							have_pend_q <= 1'b0;
							ovf_q       <= 1'b0;
							state_q     <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// payload of the held box and the output register
	always_ff @(posedge clk) begin
		if (take_ref) begin
			pend_q <= cells[0];
		end
		if (emit) begin
			out_q.kept_x       <= pend_q.x;
			out_q.kept_y       <= pend_q.y;
			out_q.kept_width   <= pend_q.w;
			out_q.kept_height  <= pend_q.h;
			out_q.kept_score   <= pend_q.score;
			out_q.kept_class   <= pend_q.cls;
			out_q.final_result <= !take_ref;
			out_q.overflowed   <= ovf_q;
		end
	end

endmodule

### hw/rtl/pcbs_cell.sv
// One chain cell: sorted insertion while loading, shift toward the head while sweeping.
module pcbs_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load_en,
	input  logic            rot_en,
	input  pcbs_pkg::entry_t new_e,
	input  pcbs_pkg::entry_t prev_e,
	input  pcbs_pkg::entry_t next_e,
	input  logic            prev_keeps,
	output pcbs_pkg::entry_t cur,
	output logic            keeps
);
	import pcbs_pkg::*;

	// equal scores stay ahead of a newcomer
	assign keeps = cur.valid && (cur.score >= new_e.score);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur <= '0;
		end else if (rot_en) begin
			cur <= next_e;
		end else if (load_en && !keeps) begin
			cur <= prev_keeps ? new_e : prev_e;
		end
	end

endmodule

### hw/rtl/pcbs_iou.sv
// Pipelined IoU test of each passing entry against the current kept box.
module pcbs_iou (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic [pcbs_pkg::THR_W-1:0]  thr,
	input  pcbs_pkg::entry_t            ref_e,
	input  pcbs_pkg::entry_t            e_in,
	output pcbs_pkg::entry_t            e_out
);
	import pcbs_pkg::*;

	logic signed [18:0] ax1, ax2, ay1, ay2, bx1, bx2, by1, by2;
	logic signed [18:0] lox, hix, loy, hiy, dx, dy;
	logic [16:0] iw, ih;
	logic [51:0] lhs, rhs;
	logic        sup;

	entry_t      e_s1, e_s2, e_s3, e_s4;
	logic        match_s1, match_s2, match_s3, match_s4;
	logic [16:0] iw_s1, ih_s1;
	logic [15:0] aw_s1, ah_s1, bw_s1, bh_s1;
	logic [33:0] inter_s2, inter_s3, inter_s4;
	logic [31:0] areaa_s2, areab_s2;
	logic [34:0] uni_s3;
	logic [34:0] plo_s4;
	logic [33:0] phi_s4;
	logic        uzero_s4;

	// edges at twice scale
	always_comb begin
		ax1 = $signed({2'b00, ref_e.x, 1'b0}) - $signed({3'b000, ref_e.w});
		ax2 = $signed({2'b00, ref_e.x, 1'b0}) + $signed({3'b000, ref_e.w});
		ay1 = $signed({2'b00, ref_e.y, 1'b0}) - $signed({3'b000, ref_e.h});
		ay2 = $signed({2'b00, ref_e.y, 1'b0}) + $signed({3'b000, ref_e.h});
		bx1 = $signed({2'b00, e_in.x, 1'b0}) - $signed({3'b000, e_in.w});
		bx2 = $signed({2'b00, e_in.x, 1'b0}) + $signed({3'b000, e_in.w});
		by1 = $signed({2'b00, e_in.y, 1'b0}) - $signed({3'b000, e_in.h});
		by2 = $signed({2'b00, e_in.y, 1'b0}) + $signed({3'b000, e_in.h});
		lox = (ax1 > bx1) ? ax1 : bx1;
		hix = (ax2 < bx2) ? ax2 : bx2;
		loy = (ay1 > by1) ? ay1 : by1;
		hiy = (ay2 < by2) ? ay2 : by2;
		dx  = hix - lox;
		dy  = hiy - loy;
		iw  = (hix > lox) ? dx[16:0] : 17'd0;
		ih  = (hiy > loy) ? dy[16:0] : 17'd0;
	end

	always_comb begin
		lhs   = {2'b00, inter_s4, 16'd0};
		rhs   = {phi_s4, 18'd0} + 52'(plo_s4);
		sup   = match_s4 && !uzero_s4 && (lhs > rhs);
		e_out = e_s4;
		e_out.valid = e_s4.valid && !sup;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_s1 <= '0;
			e_s2 <= '0;
			e_s3 <= '0;
			e_s4 <= '0;
			match_s1 <= 1'b0;
			match_s2 <= 1'b0;
			match_s3 <= 1'b0;
			match_s4 <= 1'b0;
		end else if (adv) begin
			e_s1 <= e_in;
			e_s2 <= e_s1;
			e_s3 <= e_s2;
			e_s4 <= e_s3;
			match_s1 <= e_in.valid && (e_in.cls == ref_e.cls);
			match_s2 <= match_s1;
			match_s3 <= match_s2;
			match_s4 <= match_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			iw_s1    <= iw;
			ih_s1    <= ih;
			aw_s1    <= ref_e.w;
			ah_s1    <= ref_e.h;
			bw_s1    <= e_in.w;
			bh_s1    <= e_in.h;
			inter_s2 <= 34'(iw_s1) * 34'(ih_s1);
			areaa_s2 <= 32'(aw_s1) * 32'(ah_s1);
			areab_s2 <= 32'(bw_s1) * 32'(bh_s1);
			inter_s3 <= inter_s2;
			uni_s3   <= {1'b0, areaa_s2, 2'b00} + {1'b0, areab_s2, 2'b00} - {1'b0, inter_s2};
			inter_s4 <= inter_s3;
			plo_s4   <= 35'(thr) * 35'(uni_s3[17:0]);
			phi_s4   <= 34'(thr) * 34'(uni_s3[34:18]);
			uzero_s4 <= (uni_s3 == 35'd0);
		end
	end

endmodule

### hw/rtl/pcbs_checker.sv
// Port-level checks for the box suppression block, bound to the top level.
module pcbs_props (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input pcbs_pkg::in_t               in_data,
	input logic                        out_valid,
	input logic                        out_stall,
	input pcbs_pkg::out_t              out_data
);
	import pcbs_pkg::*;

	// held result transaction keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output changed while stalled");

	// end of set closes the input until the sweep is over
	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.last_in_set |=> in_stall)
		else $error("input open right after end of set");

	// nothing follows the final result at once
	a_final_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && out_data.final_result |=> !out_valid)
		else $error("result right after final result");

	// input only opens with no unfinished set on the output
	a_open_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !(out_valid && !out_data.final_result))
		else $error("input open mid-set");

endmodule

bind per_class_box_suppression pcbs_props u_pcbs_props (.*);
